>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the k-mer match counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kqmc_pkg.sv
// Shared constants, types and helper functions of the k-mer match counter.
package kqmc_pkg;

	localparam int QUERY_ENTRIES_DEF = 32;
	localparam int COUNT_BITS_DEF    = 32;

	localparam int KMER_W     = 64;
	localparam int KLEN_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int IDX_FIELD_W = 5;
	localparam int FUNC_W     = 2;
	localparam int OUT_CNT_W  = 32;

	localparam int S_TDATA_W  = 80;
	localparam int M_TDATA_W  = 40;
	localparam int OUT_LOADED_BIT = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// Operation codes carried in the input tuser field.
	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BASE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE   = 1'b1;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;
	localparam logic [KLEN_W-1:0] KLEN_MAX   = 6'd32;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

	typedef struct packed {
		logic [KMER_W-1:0] fwd;
		logic [KMER_W-1:0] rev;
		logic [KMER_W-1:0] mask;
		logic              full;
	} kqmc_win_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} kqmc_base_t;

	// Zero counts as one base, anything above 32 as 32.
	function automatic logic [KLEN_W-1:0] eff_len(input logic [KLEN_W-1:0] klen);
		logic [KLEN_W-1:0] k;
		begin
			if (klen == '0) k = 6'd1;
			else if (klen > KLEN_MAX) k = KLEN_MAX;
			else k = klen;
			return k;
		end
	endfunction

	function automatic logic [KMER_W-1:0] len_mask(input logic [KLEN_W-1:0] k);
		logic [KMER_W-1:0] m;
		begin
			if (k >= KLEN_MAX) m = '1;
			else m = (64'd1 << {k, 1'b0}) - 64'd1;
			return m;
		end
	endfunction

	function automatic kqmc_base_t base_decode(input logic [CHAR_W-1:0] ch);
		kqmc_base_t b;
		begin
			b.ok = 1'b1;
			unique case (ch)
				CHAR_A: b.code = 2'd0;
				CHAR_C: b.code = 2'd1;
				CHAR_G: b.code = 2'd2;
				CHAR_T: b.code = 2'd3;
				default: begin
					b.ok   = 1'b0;
					b.code = 2'd0;
				end
			endcase
			return b;
		end
	endfunction

endpackage

>>> rtl/kqmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kqmc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/kqmc_window.sv
// Forward and reverse-complement k-mer windows with the valid base run.
module kqmc_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       first,
	input  logic [kqmc_pkg::CHAR_W-1:0] base_char,
	input  logic [kqmc_pkg::KLEN_W-1:0] kmer_len,
	output kqmc_pkg::kqmc_win_t        win
);
	import kqmc_pkg::*;

	logic [KMER_W-1:0] fwd_q, rev_q;
	logic [KLEN_W-1:0] run_q;
	logic [KLEN_W-1:0] k;
	logic [KMER_W-1:0] m;
	logic [KLEN_W-1:0] top_sh;
	kqmc_base_t        b;
	logic [KMER_W-1:0] fwd0, rev0, fwd_n, rev_n;
	logic [KLEN_W-1:0] run0, run_n;

	assign k      = eff_len(kmer_len);
	assign m      = len_mask(k);
	assign top_sh = {5'(k - 6'd1), 1'b0};
	assign b      = base_decode(base_char);

	always_comb begin
		fwd0 = first ? '0 : fwd_q;
		rev0 = first ? '0 : rev_q;
		run0 = first ? '0 : run_q;
		if (b.ok) begin
			fwd_n = ((fwd0 << 2) | KMER_W'(b.code)) & m;
			rev_n = ((rev0 >> 2) | (KMER_W'(2'd3 - b.code) << top_sh)) & m;
			run_n = (run0 < k) ? run0 + 6'd1 : run0;
		end else begin
			fwd_n = '0;
			rev_n = '0;
			run_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
			run_q <= '0;
		end else if (take) begin
			fwd_q <= fwd_n;
			rev_q <= rev_n;
			run_q <= run_n;
		end
	end

	assign win.fwd  = fwd_q;
	assign win.rev  = rev_q;
	assign win.mask = m;
	assign win.full = (run_q >= k);

endmodule

>>> rtl/kqmc_match.sv
// Compare and saturating increment unit; a single instance serves every table entry in turn.
module kqmc_match #(
	parameter int CNT_W = kqmc_pkg::COUNT_BITS_DEF
) (
	input  kqmc_pkg::kqmc_win_t          win,
	input  logic [kqmc_pkg::KMER_W-1:0]  query,
	input  logic                         entry_ok,
	input  logic [CNT_W-1:0]             count_in,
	output logic [CNT_W-1:0]             count_out,
	output logic                         hit
);
	import kqmc_pkg::*;

	logic [KMER_W-1:0] q;
	logic [1:0]        add;
	logic [CNT_W:0]    sum;

	assign q   = query & win.mask;
	assign add = entry_ok ? (2'(q == win.fwd) + 2'(q == win.rev)) : 2'd0;
	assign hit = (add != 2'd0);
	assign sum = {1'b0, count_in} + (CNT_W + 1)'(add);
	// The increment is at most two, so a carry out means the count topped out.
	assign count_out = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

endmodule

>>> rtl/kmer_query_match_counter_unit.sv
// Top level of the k-mer query match counter: sequencer, table memories, ports.
//
//  Channel   Signals                                   Carries
//  --------  ----------------------------------------  ---------------------------------
//  input     s_tvalid s_tready s_tuser s_tdata         load, read base, count read
//  output    m_tvalid m_tready m_tdata                 one count per count read
//  config    cfg_we cfg_index cfg_data                 kmer_len, single_count
//
// A load transaction completes at its accepting edge. A count read reads the table
// memory at the accepting edge; the result register is loaded from the read state
// once it is empty or being drained, so it waits only while the previous result is
// still held by the consumer.
// A read base passes through the start state and, when a full k-mer is ready and
// the read is not stopped, through the scan state: one compare and saturating increment
// unit visits the table entries one per cycle through the read ports of the
// two table memories, writing each updated count back as its read data arrives.
// The input side is held not ready until the current transaction is done.
// Reset clears the windows, the read stop, the loaded flags and the
// configuration registers; the table memories themselves are never cleared,
// since the data of an entry that no load has written is always masked off.
module kmer_query_match_counter_unit #(
	parameter int QUERY_ENTRIES = kqmc_pkg::QUERY_ENTRIES_DEF,
	parameter int COUNT_BITS    = kqmc_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata, low bit up: base_char[7:0], first_in_read[8], entry_index[13:9],
	// entry_kmer[77:14], zero fill[79:78].
	input  logic [kqmc_pkg::S_TDATA_W-1:0]    s_tdata,
	// tuser: func[1:0].
	input  logic [kqmc_pkg::FUNC_W-1:0]       s_tuser,
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata, low bit up: entry_count[31:0], entry_loaded[32], zero fill[39:33].
	output logic [kqmc_pkg::M_TDATA_W-1:0]    m_tdata,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [kqmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kqmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kqmc_pkg::*;

	localparam int IDX_W = (QUERY_ENTRIES > 1) ? $clog2(QUERY_ENTRIES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_RD
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [KLEN_W-1:0] kmer_len_q;
	logic              single_q;

	// Input fields.
	logic [FUNC_W-1:0]      func;
	logic [CHAR_W-1:0]      base_char;
	logic                   first_in_read;
	logic [IDX_FIELD_W-1:0] entry_index;
	logic [KMER_W-1:0]      entry_kmer;

	logic             accept;
	logic             idx_ok;
	logic [IDX_W-1:0] idx_a;

	// Scan bookkeeping.
	logic [IDX_W-1:0]         addr_s1;
	logic                     any_q;
	logic                     stopped_q;
	logic [QUERY_ENTRIES-1:0] entry_valid_q;
	logic                     rd_loaded_q;
	logic                     last;
	logic                     go;

	// Memory ports.
	logic                  q_we, c_we, mem_re;
	logic [IDX_W-1:0]      c_waddr, mem_raddr;
	logic [COUNT_BITS-1:0] c_wdata, c_rdata, new_count;
	logic [KMER_W-1:0]     q_rdata;

	kqmc_win_t win;
	logic      hit;

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic                  out_load;

	assign func          = s_tuser;
	assign base_char     = s_tdata[7:0];
	assign first_in_read = s_tdata[8];
	assign entry_index   = s_tdata[13:9];
	assign entry_kmer    = s_tdata[77:14];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign idx_ok   = (32'(entry_index) < 32'(QUERY_ENTRIES));
	assign idx_a    = IDX_W'(entry_index);
	assign last     = (32'(addr_s1) == 32'(QUERY_ENTRIES - 1));
	assign go       = win.full && !stopped_q;
	// The result register takes a new count once it is empty or being drained.
	assign out_load = (state_q == ST_RD) && (!m_tvalid_q || m_tready);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q <= KLEN_RESET;
			single_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KMER_LEN: kmer_len_q <= cfg_data;
				CFG_SINGLE:   single_q   <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	kqmc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (accept && (func == FUNC_BASE)),
		.first     (first_in_read),
		.base_char (base_char),
		.kmer_len  (kmer_len_q),
		.win       (win)
	);

	kqmc_match #(
		.CNT_W (COUNT_BITS)
	) u_match (
		.win       (win),
		.query     (q_rdata),
		.entry_ok  (entry_valid_q[addr_s1]),
		.count_in  (c_rdata),
		.count_out (new_count),
		.hit       (hit)
	);

	// Both memories share one read address: during a scan they deliver the
	// query and its count together, and a count read uses the count side only.
	always_comb begin
		q_we      = accept && (func == FUNC_LOAD) && idx_ok;
		c_we      = q_we || ((state_q == ST_SCAN) && hit);
		c_waddr   = (state_q == ST_SCAN) ? addr_s1 : idx_a;
		c_wdata   = (state_q == ST_SCAN) ? new_count : '0;
		mem_re    = (accept && (func == FUNC_READ)) ||
		            ((state_q == ST_START) && go) ||
		            ((state_q == ST_SCAN) && !last);
		unique case (state_q)
			ST_START: mem_raddr = '0;
			ST_SCAN:  mem_raddr = addr_s1 + IDX_W'(1);
			default:  mem_raddr = idx_a;
		endcase
	end

	kqmc_ram #(
		.WIDTH (KMER_W),
		.DEPTH (QUERY_ENTRIES)
	) u_query_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (idx_a),
		.wdata (entry_kmer),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (q_rdata)
	);

	kqmc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (QUERY_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (c_rdata)
	);

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			addr_s1       <= '0;
			any_q         <= 1'b0;
			stopped_q     <= 1'b0;
			entry_valid_q <= '0;
			rd_loaded_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_LOAD: begin
								if (idx_ok) begin
									entry_valid_q[idx_a] <= 1'b1;
								end
							end
							FUNC_BASE: begin
								if (first_in_read) begin
									stopped_q <= 1'b0;
								end
								state_q <= ST_START;
							end
							FUNC_READ: begin
								rd_loaded_q <= idx_ok && entry_valid_q[idx_a];
								state_q     <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_START: begin
					// The windows now hold the new base; scan only if a full
					// k-mer is there and the read has not been stopped.
					addr_s1 <= '0;
					any_q   <= 1'b0;
					state_q <= go ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (hit) begin
						any_q <= 1'b1;
					end
					if (last) begin
						if (single_q && (any_q || hit)) begin
							stopped_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						addr_s1 <= addr_s1 + IDX_W'(1);
					end
				end
				ST_RD: begin
					if (out_load) begin
						m_tdata_q  <= {{(M_TDATA_W - OUT_CNT_W - 1){1'b0}}, rd_loaded_q,
						               rd_loaded_q ? OUT_CNT_W'(c_rdata) : '0};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/kqmc_chk.sv
// Port-level checker for the k-mer match counter, bound to the top level.
`include "assert_macros.svh"

module kqmc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [kqmc_pkg::FUNC_W-1:0]    s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [kqmc_pkg::M_TDATA_W-1:0] m_tdata
);
	import kqmc_pkg::*;

	logic acc_base_or_read;
	logic acc_read;

	assign acc_read         = s_tvalid && s_tready && (s_tuser == FUNC_READ);
	assign acc_base_or_read = s_tvalid && s_tready &&
	                          ((s_tuser == FUNC_BASE) || (s_tuser == FUNC_READ));

	// A held result keeps its value until it is taken.
	`KQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Base and count-read transactions leave the input side not ready right after they are accepted.
	`KQ_ASSERT_NEXT(a_busy_after, clk, arst_n, acc_base_or_read, !s_tready, "input ready right after a multi-cycle transaction")

	// A result that raises tvalid is registered at the clock edge right after its count read was taken.
	`KQ_ASSERT_IMPL(a_rise_src, clk, arst_n, $rose(m_tvalid), $past(acc_read, 2), "result without a matching count read")

	// An entry that was never loaded always reports a zero count.
	`KQ_ASSERT_IMPL(a_unloaded_zero, clk, arst_n, m_tvalid && !m_tdata[OUT_LOADED_BIT], m_tdata[OUT_CNT_W-1:0] == '0, "unloaded entry with nonzero count")

endmodule

bind kmer_query_match_counter_unit kqmc_chk u_kqmc_chk (.*);

>>> verif/kmer_query_match_counter_unit_test.sv
// Self-checking testbench of the k-mer query match counter: directed cases, random reads, stalls.
module kmer_query_match_counter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kqmc_pkg::*;

	// The package names the three operations. The fourth code is left unused,
	// and the block must drop it without a result.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
	localparam int TABLE_DEPTH = QUERY_ENTRIES_DEF;
	// A base that completes a k-mer keeps the block busy for the start state and one
	// pass over the table. The rest pause before a register write covers that pass
	// with some margin.
	localparam int REST_CYCLES = QUERY_ENTRIES_DEF + 8;
	// The long output stall that makes the block fill up and refuse input.
	localparam int STALL_CYCLES = 300;

	// One expected count-read result, tagged with the entry it asks for.
	typedef struct packed {
		logic [IDX_FIELD_W-1:0] entry;
		logic [OUT_CNT_W-1:0]   count;
		logic                   loaded;
	} count_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = FUNC_LOAD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_KMER_LEN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block: registers, windows and the query table.
	logic [KLEN_W-1:0] klen_reg;
	logic              single_reg;
	logic [KMER_W-1:0] fwd_win;
	logic [KMER_W-1:0] rev_win;
	int                run_len;
	logic              read_halted;
	logic [KMER_W-1:0]    table_kmer [TABLE_DEPTH];
	logic                 table_loaded [TABLE_DEPTH];
	logic [OUT_CNT_W-1:0] table_hits [TABLE_DEPTH];

	// Count-read results that the block still owes, oldest first.
	count_result_t pending_counts [$];

	// Bases of the read that the current random round streams in.
	logic [CHAR_W-1:0] read_bases [$];

	int mismatches = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit stall_request = 1'b0;

	kmer_query_match_counter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fallback limit: the slowest legal run stays far below two milliseconds.
	initial begin
		#2000000;
		$display("FAIL kmer_query_match_counter_unit");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A k-mer length of zero behaves as one base, anything above 32 as 32.
	function automatic int span_of(input logic [KLEN_W-1:0] klen);
		if (klen == '0)
			return 1;
		if (klen > KLEN_MAX)
			return 32;
		return int'(klen);
	endfunction

	function automatic logic [KMER_W-1:0] span_mask(input int k);
		if (k >= 32)
			return '1;
		return (64'd1 << (2 * k)) - 64'd1;
	endfunction

	// Two-bit code of a nucleotide, or -1 for any other character.
	function automatic int char_code(input logic [CHAR_W-1:0] ch);
		case (ch)
			CHAR_A: return 0;
			CHAR_C: return 1;
			CHAR_G: return 2;
			CHAR_T: return 3;
			default: return -1;
		endcase
	endfunction

	function automatic void restart_window();
		fwd_win = '0;
		rev_win = '0;
		run_len = 0;
	endfunction

	// Moves one base into both windows and, once a whole k-mer is present and
	// the read is not halted, scores every loaded entry against it.
	function automatic void shift_base(input logic [CHAR_W-1:0] ch);
		int k;
		int code;
		logic [KMER_W-1:0] m;
		logic [KMER_W-1:0] q;
		logic [KMER_W-1:0] comp;
		logic [1:0] add;
		logic [OUT_CNT_W:0] sum;
		logic any_hit;
		k = span_of(klen_reg);
		m = span_mask(k);
		code = char_code(ch);
		any_hit = 1'b0;
		if (code < 0) begin
			restart_window();
			return;
		end
		comp = KMER_W'(3 - code);
		fwd_win = ((fwd_win << 2) | KMER_W'(code)) & m;
		rev_win = ((rev_win >> 2) | (comp << (2 * (k - 1)))) & m;
		if (run_len < k)
			run_len++;
		if (run_len < k || read_halted)
			return;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!table_loaded[i])
				continue;
			q = table_kmer[i] & m;
			// A palindromic window matches through both strands and scores twice.
			add = {1'b0, q == fwd_win} + {1'b0, q == rev_win};
			if (add == 2'd0)
				continue;
			any_hit = 1'b1;
			sum = {1'b0, table_hits[i]} + (OUT_CNT_W + 1)'(add);
			table_hits[i] = sum[OUT_CNT_W] ? '1 : sum[OUT_CNT_W-1:0];
		end
		if (any_hit && single_reg)
			read_halted = 1'b1;
	endfunction

	// Applies one accepted transaction to the shadow state and queues the
	// result that it owes, if any.
	function automatic void predict_item(input logic [FUNC_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic first,
			input logic [IDX_FIELD_W-1:0] idx, input logic [KMER_W-1:0] kmer);
		count_result_t res;
		case (op)
			FUNC_LOAD: begin
				table_kmer[idx] = kmer;
				table_loaded[idx] = 1'b1;
				table_hits[idx] = '0;
			end
			FUNC_BASE: begin
				if (first) begin
					restart_window();
					read_halted = 1'b0;
				end
				shift_base(ch);
			end
			FUNC_READ: begin
				res.entry = idx;
				res.loaded = table_loaded[idx];
				res.count = table_loaded[idx] ? table_hits[idx] : '0;
				pending_counts = {pending_counts, res};
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [KMER_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly clean nucleotides, now and then an N or an arbitrary byte.
	function automatic logic [CHAR_W-1:0] pick_base();
		int sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return CHAR_N;
		if (sel < 8)
			return CHAR_W'($urandom_range(255));
		case ($urandom_range(3))
			0: return CHAR_A;
			1: return CHAR_C;
			2: return CHAR_G;
			default: return CHAR_T;
		endcase
	endfunction

	// Packs k bases of the current read starting at pos, either as the
	// forward window would hold them or as the reverse-complement window would.
	// Characters other than ACGT are treated as A, so they appear as T in the reverse-complement packing.
	function automatic logic [KMER_W-1:0] pack_span(input int pos, input int k,
			input bit revcomp);
		logic [KMER_W-1:0] v;
		int code;
		v = '0;
		for (int j = 0; j < k; j++) begin
			code = char_code(read_bases[revcomp ? pos + k - 1 - j : pos + j]);
			if (code < 0)
				code = 0;
			if (revcomp)
				code = 3 - code;
			v = (v << 2) | KMER_W'(code);
		end
		return v;
	endfunction

	// Offers one transaction after a random gap and returns in the time step of
	// the clock edge that accepts it. tvalid stays high on return, so the next
	// call either keeps it up or opens a gap.
	task automatic send_item(input logic [FUNC_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic first, input logic [IDX_FIELD_W-1:0] idx,
			input logic [KMER_W-1:0] kmer);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, kmer, idx, first, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(op, ch, first, idx, kmer);
		if (op != FUNC_SPARE)
			items_sent++;
	endtask

	// The fields an operation ignores carry random values.
	task automatic send_load(input logic [IDX_FIELD_W-1:0] idx, input logic [KMER_W-1:0] kmer);
		send_item(FUNC_LOAD, CHAR_W'($urandom), 1'($urandom), idx, kmer);
	endtask

	task automatic send_base(input logic [CHAR_W-1:0] ch, input logic first);
		send_item(FUNC_BASE, ch, first, IDX_FIELD_W'($urandom), rand64());
	endtask

	task automatic send_read(input logic [IDX_FIELD_W-1:0] idx);
		send_item(FUNC_READ, CHAR_W'($urandom), 1'($urandom), idx, rand64());
	endtask

	task automatic send_spare();
		send_item(FUNC_SPARE, CHAR_W'($urandom), 1'($urandom), IDX_FIELD_W'($urandom),
			rand64());
	endtask

	// Stops offering input, waits for every owed result, then lets the block
	// finish any table pass that produces no result.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (REST_CYCLES)
			@(posedge clk);
	endtask

	// Register writes happen only while the block is idle.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KMER_LEN)
			klen_reg = value;
		else
			single_reg = value[0];
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Entries that were never loaded read back as count 0, not loaded, and
	// the unused operation code yields nothing.
	task automatic test_unloaded_entries();
		send_read(5'd0);
		send_spare();
		send_read(5'd31);
		send_read(IDX_FIELD_W'($urandom));
	endtask

	// Two-base k-mers: a palindrome scoring on both strands, stored bits above
	// the k-mer length being ignored, an N restarting the window, and a
	// reverse-complement only hit.
	task automatic test_window_and_palindrome();
		drain_block();
		cfg_write(CFG_KMER_LEN, 6'd2);
		cfg_write(CFG_SINGLE, 6'd0);
		// AT is its own reverse complement; the upper bits are all ones.
		send_load(5'd0, 64'hFFFF_FFFF_FFFF_FFF3);
		// CA is the reverse complement of TG.
		send_load(5'd31, (rand64() & ~span_mask(2)) | 64'h4);
		send_base(CHAR_A, 1'b1);
		send_base(CHAR_T, 1'b0);
		send_base(CHAR_N, 1'b0);
		send_base(CHAR_T, 1'b0);
		send_base(CHAR_G, 1'b0);
		send_read(5'd0);
		send_read(5'd31);
	endtask

	// Single-count mode: after the first hitting k-mer the read is halted
	// until the next first base, even across a window restart. A length of
	// zero acts as one base.
	task automatic test_single_count_stop();
		drain_block();
		cfg_write(CFG_KMER_LEN, 6'd0);
		cfg_write(CFG_SINGLE, 6'd1);
		send_load(5'd1, rand64() & ~span_mask(1));
		send_base(CHAR_A, 1'b1);
		send_base(CHAR_A, 1'b0);
		send_base(8'hFF, 1'b0);
		send_base(CHAR_A, 1'b1);
		send_base(8'h61, 1'b0);
		send_read(5'd1);
	endtask

	// One random round: pick a configuration, build a read, load entries with
	// k-mers cut from it (either strand, random upper bits) or plain random
	// ones, stream the read with some noise, then read the counts back.
	task automatic run_read_round(input int round_no);
		int sel;
		int k;
		int len;
		int pos;
		logic [KLEN_W-1:0] klen;
		logic [KMER_W-1:0] m;
		logic [KMER_W-1:0] kmer;
		logic [IDX_FIELD_W-1:0] idx;
		logic [IDX_FIELD_W-1:0] loaded_idx [$];
		drain_block();
		case (round_no)
			0: klen = KLEN_MAX;
			1: klen = 6'd1;
			2: klen = 6'd63;
			default: begin
				sel = $urandom_range(99);
				if (sel < 65)
					klen = KLEN_W'($urandom_range(1, 6));
				else if (sel < 80)
					klen = KLEN_W'($urandom_range(7, 31));
				else if (sel < 88)
					klen = KLEN_MAX;
				else if (sel < 94)
					klen = '0;
				else
					klen = KLEN_W'($urandom_range(33, 63));
			end
		endcase
		cfg_write(CFG_KMER_LEN, klen);
		// Only bit 0 of the single-count register matters; the rest is noise.
		cfg_write(CFG_SINGLE, {5'($urandom), 1'($urandom_range(99) < 30)});
		k = span_of(klen_reg);
		m = span_mask(k);
		len = k + $urandom_range(0, k > 8 ? 6 : 10);
		read_bases.delete();
		for (int i = 0; i < len; i++)
			read_bases = {read_bases, pick_base()};
		repeat ($urandom_range(1, 4)) begin
			idx = IDX_FIELD_W'($urandom);
			if ($urandom_range(99) < 80) begin
				pos = $urandom_range(0, len - k);
				kmer = (rand64() & ~m) | pack_span(pos, k, 1'($urandom));
			end else begin
				kmer = rand64();
			end
			send_load(idx, kmer);
			loaded_idx = {loaded_idx, idx};
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 4)
				send_spare();
			if ($urandom_range(99) < 6)
				send_read(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
			// A stray first-base flag now and then breaks the read in two.
			send_base(read_bases[i], i == 0 || $urandom_range(99) < 3);
		end
		foreach (loaded_idx[i])
			send_read(loaded_idx[i]);
		send_read(IDX_FIELD_W'($urandom));
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int target);
		int start;
		int round_no;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		round_no = 0;
		while (items_sent - start < target) begin
			run_read_round(round_no);
			round_no++;
		end
	endtask

	// The receiver holds off for a long stretch while count reads keep coming,
	// so the output register fills and the block stops taking input.
	task automatic test_output_stall();
		drain_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		repeat (12)
			send_read(IDX_FIELD_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Receiver readiness: random idling, or a long counted hold-off on request.
	always begin
		@(posedge clk);
		if (stall_request) begin
			stall_request = 1'b0;
			hold_left = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result transaction is matched against the oldest owed count read.
	always @(posedge clk) begin : check_results
		count_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_counts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual count %0d loaded %0b",
					$time, m_tdata[OUT_CNT_W-1:0], m_tdata[OUT_LOADED_BIT]);
			end else begin
				want = pending_counts.pop_front();
				if (m_tdata[OUT_CNT_W-1:0] !== want.count) begin
					mismatches++;
					$display("%0t: entry %0d entry_count: expected %0d, actual %0d",
						$time, want.entry, want.count, m_tdata[OUT_CNT_W-1:0]);
				end
				if (m_tdata[OUT_LOADED_BIT] !== want.loaded) begin
					mismatches++;
					$display("%0t: entry %0d entry_loaded: expected %0b, actual %0b",
						$time, want.entry, want.loaded, m_tdata[OUT_LOADED_BIT]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		klen_reg = KLEN_RESET;
		single_reg = 1'b0;
		restart_window();
		read_halted = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			table_kmer[i] = '0;
			table_loaded[i] = 1'b0;
			table_hits[i] = '0;
		end
		send_idle_pct = 23;
		recv_idle_pct = 77;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unloaded_entries();
		test_window_and_palindrome();
		test_single_count_stop();
		test_random_traffic(23, 77, 135);
		test_random_traffic(77, 23, 135);
		test_random_traffic(0, 0, 135);
		test_output_stall();
		drain_block();

		if (mismatches == 0)
			$display("PASS kmer_query_match_counter_unit");
		else
			$display("FAIL kmer_query_match_counter_unit");
		$finish;
	end

endmodule
